@@ hw/rtl/gtva_pkg.sv @@
// ---------------------------------------------------------------------------
// gtva_pkg
// Shared types, constants and register codes for the gate-triggered voice
// allocator.
// ---------------------------------------------------------------------------
package gtva_pkg;

  localparam int DEF_NUM_VOICES  = 4;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int THR_W   = 17;
  localparam int STEP_W  = 16;
  localparam int COUNT_W = 20;
  localparam int COEF_W  = 16;
  localparam int LEVEL_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [LEVEL_W-1:0] GATE_FULL = 16'd32768;

  localparam logic [THR_W-1:0]   RST_OPEN_THRESHOLD   = 17'd65536;
  localparam logic [STEP_W-1:0]  RST_ATTACK_STEP      = 16'd32768;
  localparam logic [STEP_W-1:0]  RST_RELEASE_STEP     = 16'd32768;
  localparam logic [COUNT_W-1:0] RST_HOLD_SAMPLES     = 20'd0;
  localparam logic [COUNT_W-1:0] RST_GRAIN_SAMPLES    = 20'd96000;
  localparam logic [COEF_W-1:0]  RST_ENVELOPE_RELEASE = 16'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_THRESHOLD   = 3'd0,
    REG_ATTACK_STEP      = 3'd1,
    REG_RELEASE_STEP     = 3'd2,
    REG_HOLD_SAMPLES     = 3'd3,
    REG_GRAIN_SAMPLES    = 3'd4,
    REG_ENVELOPE_RELEASE = 3'd5
  } cfg_reg_t;

  // output phase codes
  localparam logic [1:0] PH_CLOSED  = 2'd0;
  localparam logic [1:0] PH_OPENING = 2'd1;
  localparam logic [1:0] PH_OPEN    = 2'd2;
  localparam logic [1:0] PH_CLOSING = 2'd3;

  typedef enum logic [3:0] {
    ST_CLOSED  = 4'b0001,
    ST_OPENING = 4'b0010,
    ST_OPEN    = 4'b0100,
    ST_CLOSING = 4'b1000
  } gate_state_t;

  typedef struct packed {
    logic [THR_W-1:0]   open_threshold;
    logic [STEP_W-1:0]  attack_step;
    logic [STEP_W-1:0]  release_step;
    logic [COUNT_W-1:0] hold_samples;
  } gate_cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [1:0]         phase;
    logic               start;
  } gate_res_t;

  typedef struct packed {
    logic taken;
    logic ended;
    logic busy;
  } cell_stat_t;

  function automatic logic [1:0] phase_code(gate_state_t st);
    logic [1:0] code;
    code = PH_CLOSED;
    unique case (st)
      ST_CLOSED:  code = PH_CLOSED;
      ST_OPENING: code = PH_OPENING;
      ST_OPEN:    code = PH_OPEN;
      ST_CLOSING: code = PH_CLOSING;
      default:    code = PH_CLOSED;
    endcase
    return code;
  endfunction

endpackage

@@ hw/rtl/gtva_in_if.sv @@
// ---------------------------------------------------------------------------
// gtva_in_if
// Input channel: one stereo sample pair per word, valid/ready.
// ---------------------------------------------------------------------------
interface gtva_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

@@ hw/rtl/gtva_out_if.sv @@
// ---------------------------------------------------------------------------
// gtva_out_if
// Result channel: gate state, envelope and voice events, valid/ready.
// ---------------------------------------------------------------------------
interface gtva_out_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int NUM_VOICES  = 4
);
  localparam int ENV_W = SAMPLE_BITS + 1;
  localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  logic                  valid;
  logic                  ready;
  logic [15:0]           gate_level;
  logic [1:0]            gate_phase;
  logic [ENV_W-1:0]      envelope_level;
  logic                  grain_started;
  logic [IDX_W-1:0]      started_voice;
  logic [NUM_VOICES-1:0] ended_mask;
  logic [NUM_VOICES-1:0] busy_mask;

  modport source (
    output valid, output gate_level, output gate_phase, output envelope_level,
    output grain_started, output started_voice, output ended_mask, output busy_mask,
    input ready
  );
  modport sink (
    input valid, input gate_level, input gate_phase, input envelope_level,
    input grain_started, input started_voice, input ended_mask, input busy_mask,
    output ready
  );
endinterface

@@ hw/rtl/gtva_env.sv @@
// ---------------------------------------------------------------------------
// gtva_env
// Peak envelope follower: instant attack, rounded Q0.16 exponential release.
// ---------------------------------------------------------------------------
module gtva_env
  import gtva_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic [COEF_W-1:0]             release_coef,
  output logic [SAMPLE_BITS:0]          envelope
);

  localparam int ENV_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = ENV_W + COEF_W;

  logic [ENV_W-1:0]       env_r, env_nxt;
  logic [SAMPLE_BITS-1:0] mag_l, mag_r;
  logic [ENV_W-1:0]       sum, diff, dec;
  logic [PROD_W-1:0]      prod, rnd;

  // most negative sample maps onto 2^(N-1), which fits unsigned
  assign mag_l = left_sample[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-left_sample)  : left_sample;
  assign mag_r = right_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-right_sample) : right_sample;
  assign sum   = {1'b0, mag_l} + {1'b0, mag_r};

  assign diff = env_r - sum;
  assign prod = PROD_W'(diff) * PROD_W'(release_coef);
  assign rnd  = prod + PROD_W'(32768);
  assign dec  = rnd[PROD_W-1:COEF_W];

  always_comb begin
    if (sum > env_r) begin
      env_nxt = sum;
    end else begin
      env_nxt = env_r - dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (load) begin
      env_r <= env_nxt;
    end
  end

  assign envelope = env_r;

endmodule

@@ hw/rtl/gtva_gate.sv @@
// ---------------------------------------------------------------------------
// gtva_gate
// Four-phase gate with attack/release ramps, threshold and hold counter.
// ---------------------------------------------------------------------------
module gtva_gate
  import gtva_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [SAMPLE_BITS:0] envelope,
  input  gate_cfg_t            cfg,
  output gate_res_t            res
);

  localparam int ENV_W = SAMPLE_BITS + 1;
  localparam int CMP_W = (ENV_W > THR_W) ? ENV_W : THR_W;

  gate_state_t          st_r, st_nxt;
  logic [LEVEL_W-1:0]   gate_r, gate_nxt;
  logic [COUNT_W-1:0]   hold_r, hold_nxt;
  logic [LEVEL_W:0]     up;
  logic                 thr_hit;
  logic                 start;

  assign thr_hit = CMP_W'(envelope) >= CMP_W'(cfg.open_threshold);
  assign up      = {1'b0, gate_r} + {1'b0, cfg.attack_step};

  always_comb begin
    st_nxt   = st_r;
    gate_nxt = gate_r;
    hold_nxt = hold_r;
    start    = 1'b0;
    unique case (st_r)
      ST_CLOSED: begin
        if (thr_hit) st_nxt = ST_OPENING;
      end
      ST_OPENING: begin
        if (up >= {1'b0, GATE_FULL}) begin
          gate_nxt = GATE_FULL;
          st_nxt   = ST_OPEN;
          hold_nxt = cfg.hold_samples;
          start    = 1'b1;
        end else begin
          gate_nxt = up[LEVEL_W-1:0];
        end
      end
      ST_OPEN: begin
        if (hold_r == '0) begin
          if (!thr_hit) st_nxt = ST_CLOSING;
        end else begin
          hold_nxt = hold_r - COUNT_W'(1);
        end
      end
      ST_CLOSING: begin
        gate_nxt = (gate_r > cfg.release_step) ? gate_r - cfg.release_step : '0;
        if (thr_hit) begin
          st_nxt = ST_OPENING;
        end else if (gate_nxt == '0) begin
          st_nxt = ST_CLOSED;
        end
      end
      default: begin
        st_nxt = ST_CLOSED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLOSED;
      gate_r <= '0;
      hold_r <= '0;
    end else if (adv) begin
      st_r   <= st_nxt;
      gate_r <= gate_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign res.level = gate_nxt;
  assign res.phase = phase_code(st_nxt);
  assign res.start = start;

endmodule

@@ hw/rtl/gtva_voice_cell.sv @@
// ---------------------------------------------------------------------------
// gtva_voice_cell
// One voice countdown timer; claims a start request when free, else passes it on.
// ---------------------------------------------------------------------------
module gtva_voice_cell
  import gtva_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [COUNT_W-1:0] grain_samples,
  input  logic               start_in,
  output logic               start_out,
  output cell_stat_t         stat
);

  logic [COUNT_W-1:0] rem_r, rem_nxt, loaded;
  logic               free;
  logic               take;

  assign free      = (rem_r == '0);
  assign take      = start_in & free;
  assign start_out = start_in & ~free;
  assign loaded    = take ? grain_samples : rem_r;

  // a voice loaded now is decremented in the same word
  assign rem_nxt = (loaded != '0) ? loaded - COUNT_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (adv) begin
      rem_r <= rem_nxt;
    end
  end

  assign stat.taken = take;
  assign stat.ended = (loaded != '0) && (rem_nxt == '0);
  assign stat.busy  = (rem_nxt != '0);

endmodule

@@ hw/rtl/gate_triggered_voice_allocator.sv @@
// ---------------------------------------------------------------------------
// gate_triggered_voice_allocator
// Envelope-driven noise gate that starts the lowest free voice timer on open.
// ---------------------------------------------------------------------------
//  port      dir  handshake         contents
//  in_chan   in   valid/ready       left_sample, right_sample
//  out_chan  out  valid/ready       gate level/phase, envelope, voice events
//  cfg_*     in   write enable only register index, write data
//
//  One word per cycle sustained while out_chan is ready; registered in the
//  envelope register, then gate and voice cells into the output register. The
//  envelope recurrence, one multiply plus subtract per cycle, sets the clock.
//  Synchronous active-low reset clears state; no clearing pass is needed.
//  A stalled output holds its word while the envelope stage keeps one more.
// ---------------------------------------------------------------------------
module gate_triggered_voice_allocator
  import gtva_pkg::*;
#(
  parameter int NUM_VOICES  = DEF_NUM_VOICES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gtva_in_if.sink               in_chan,
  gtva_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ENV_W = SAMPLE_BITS + 1;
  localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  // configuration registers
  logic [THR_W-1:0]   open_threshold_r;
  logic [STEP_W-1:0]  attack_step_r;
  logic [STEP_W-1:0]  release_step_r;
  logic [COUNT_W-1:0] hold_samples_r;
  logic [COUNT_W-1:0] grain_samples_r;
  logic [COEF_W-1:0]  envelope_release_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_threshold_r   <= RST_OPEN_THRESHOLD;
      attack_step_r      <= RST_ATTACK_STEP;
      release_step_r     <= RST_RELEASE_STEP;
      hold_samples_r     <= RST_HOLD_SAMPLES;
      grain_samples_r    <= RST_GRAIN_SAMPLES;
      envelope_release_r <= RST_ENVELOPE_RELEASE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OPEN_THRESHOLD:   open_threshold_r   <= cfg_data[THR_W-1:0];
        REG_ATTACK_STEP:      attack_step_r      <= cfg_data[STEP_W-1:0];
        REG_RELEASE_STEP:     release_step_r     <= cfg_data[STEP_W-1:0];
        REG_HOLD_SAMPLES:     hold_samples_r     <= cfg_data[COUNT_W-1:0];
        REG_GRAIN_SAMPLES:    grain_samples_r    <= cfg_data[COUNT_W-1:0];
        REG_ENVELOPE_RELEASE: envelope_release_r <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic a_v_r, a_v_nxt;
  logic out_v_r, out_v_nxt;
  logic in_acc, out_load;

  assign out_load      = a_v_r & (~out_v_r | out_chan.ready);
  assign in_chan.ready = ~a_v_r | out_load;
  assign in_acc        = in_chan.valid & in_chan.ready;

  always_comb begin
    a_v_nxt   = in_acc ? 1'b1 : (out_load ? 1'b0 : a_v_r);
    out_v_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r   <= a_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // envelope stage
  logic [ENV_W-1:0] envelope;

  gtva_env #(.SAMPLE_BITS(SAMPLE_BITS)) u_env (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_acc),
    .left_sample  (in_chan.left_sample),
    .right_sample (in_chan.right_sample),
    .release_coef (envelope_release_r),
    .envelope     (envelope)
  );

  // gate stage
  gate_cfg_t gate_cfg;
  gate_res_t gate_res;

  assign gate_cfg.open_threshold = open_threshold_r;
  assign gate_cfg.attack_step    = attack_step_r;
  assign gate_cfg.release_step   = release_step_r;
  assign gate_cfg.hold_samples   = hold_samples_r;

  gtva_gate #(.SAMPLE_BITS(SAMPLE_BITS)) u_gate (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (out_load),
    .envelope (envelope),
    .cfg      (gate_cfg),
    .res      (gate_res)
  );

  // voice cells: the start request ripples to the lowest free voice
  logic [NUM_VOICES:0]   start_c;
  cell_stat_t            stat [NUM_VOICES];
  logic [NUM_VOICES-1:0] taken, ended, busy;

  assign start_c[0] = gate_res.start;

  for (genvar gi = 0; gi < NUM_VOICES; gi++) begin : g_voice
    gtva_voice_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .adv           (out_load),
      .grain_samples (grain_samples_r),
      .start_in      (start_c[gi]),
      .start_out     (start_c[gi+1]),
      .stat          (stat[gi])
    );
    assign taken[gi] = stat[gi].taken;
    assign ended[gi] = stat[gi].ended;
    assign busy[gi]  = stat[gi].busy;
  end

  logic [IDX_W-1:0] voice_idx;

  always_comb begin
    voice_idx = '0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      voice_idx = voice_idx | (taken[i] ? IDX_W'(i) : '0);
    end
  end

  // output register
  logic [LEVEL_W-1:0]    gate_level_r;
  logic [1:0]            gate_phase_r;
  logic [ENV_W-1:0]      envelope_level_r;
  logic                  grain_started_r;
  logic [IDX_W-1:0]      started_voice_r;
  logic [NUM_VOICES-1:0] ended_mask_r;
  logic [NUM_VOICES-1:0] busy_mask_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      gate_level_r     <= gate_res.level;
      gate_phase_r     <= gate_res.phase;
      envelope_level_r <= envelope;
      grain_started_r  <= |taken;
      started_voice_r  <= voice_idx;
      ended_mask_r     <= ended;
      busy_mask_r      <= busy;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.gate_level     = gate_level_r;
  assign out_chan.gate_phase     = gate_phase_r;
  assign out_chan.envelope_level = envelope_level_r;
  assign out_chan.grain_started  = grain_started_r;
  assign out_chan.started_voice  = started_voice_r;
  assign out_chan.ended_mask     = ended_mask_r;
  assign out_chan.busy_mask      = busy_mask_r;

`ifndef ASSERT_OFF
  a_one_taker : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(taken))
    else $error("more than one voice took the start request");

  a_end_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_chan.ended_mask & out_chan.busy_mask) == '0)
    else $error("voice reported ended and busy in the same word");

  a_start_on_open : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.grain_started |->
      out_chan.gate_phase == PH_OPEN && out_chan.gate_level == GATE_FULL)
    else $error("voice started while gate not fully open");

  a_closed_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.gate_phase == PH_CLOSED |-> out_chan.gate_level == '0)
    else $error("closed gate with nonzero level");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the gate-triggered voice allocator. A scoreboard
// class predicts each output word from the accepted sample pair and compares
// it field by field; sender and receiver idle at random around gate bursts.
// ---------------------------------------------------------------------------
module tb;
  import gtva_pkg::*;

  localparam int SB          = DEF_SAMPLE_BITS;
  localparam int VOICES      = DEF_NUM_VOICES;
  localparam int ENV_BITS    = SB + 1;
  localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ENV_MASK    = (1 << ENV_BITS) - 1;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic signed [SB-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SB-1:0] S_MIN = 16'sh8000;

  // indexes past the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {SET_TYPICAL, SET_STARVED, SET_RAW, SET_MIN, SET_ALL_ONES, SET_MAX}
    setting_kind_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  gate_level;
    logic [1:0]          gate_phase;
    logic [ENV_BITS-1:0] envelope_level;
    logic                grain_started;
    logic [VIDX_W-1:0]   started_voice;
    logic [VOICES-1:0]   ended_mask;
    logic [VOICES-1:0]   busy_mask;
  } gate_word_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] threshold;
    logic [CFG_DATA_W-1:0] attack;
    logic [CFG_DATA_W-1:0] rls_step;
    logic [CFG_DATA_W-1:0] hold;
    logic [CFG_DATA_W-1:0] grain;
    logic [CFG_DATA_W-1:0] env_coef;
  } gate_setting_t;

  class gate_scoreboard;
    int unsigned thr, atk, rls, hold_len, grain_len, env_coef;
    int unsigned env, gate, hold_cnt;
    logic [1:0]  phase;
    int unsigned remain[VOICES];
    bit          free_ok;
    int unsigned free_idx;
    gate_word_t  words_due[$];
    int unsigned failures;

    function new();
      thr       = RST_OPEN_THRESHOLD;
      atk       = RST_ATTACK_STEP;
      rls       = RST_RELEASE_STEP;
      hold_len  = RST_HOLD_SAMPLES;
      grain_len = RST_GRAIN_SAMPLES;
      env_coef  = RST_ENVELOPE_RELEASE;
      env       = 0;
      gate      = 0;
      phase     = PH_CLOSED;
      hold_cnt  = 0;
      foreach (remain[v]) remain[v] = 0;
      free_ok   = 1'b1;
      free_idx  = 0;
      failures  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OPEN_THRESHOLD:   thr       = data[THR_W-1:0];
        REG_ATTACK_STEP:      atk       = data[STEP_W-1:0];
        REG_RELEASE_STEP:     rls       = data[STEP_W-1:0];
        REG_HOLD_SAMPLES:     hold_len  = data[COUNT_W-1:0];
        REG_GRAIN_SAMPLES:    grain_len = data[COUNT_W-1:0];
        REG_ENVELOPE_RELEASE: env_coef  = data[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    static function int unsigned magnitude(logic signed [SB-1:0] s);
      int v;
      v = s;
      return (v < 0) ? -v : v;
    endfunction

    function void note_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
      int unsigned     sum;
      longint unsigned dec;
      gate_word_t      w;
      w   = '0;
      sum = magnitude(l) + magnitude(r);
      // instant attack, rounded fractional release
      if (sum > env) env = sum;
      else begin
        dec = 64'(env - sum) * 64'(env_coef) + 64'd32768;
        env = env - 32'(dec >> 16);
      end
      env &= ENV_MASK;

      case (phase)
        PH_CLOSED: if (env >= thr) phase = PH_OPENING;
        PH_OPENING: begin
          gate += atk;
          if (gate >= GATE_FULL) begin
            gate     = GATE_FULL;
            phase    = PH_OPEN;
            hold_cnt = hold_len;
            if (free_ok) begin
              remain[free_idx] = grain_len;
              w.grain_started  = 1'b1;
              w.started_voice  = VIDX_W'(free_idx);
            end
          end
        end
        PH_OPEN: begin
          if (hold_cnt == 0) begin
            if (env < thr) phase = PH_CLOSING;
          end else hold_cnt--;
        end
        default: begin
          gate = (gate > rls) ? gate - rls : 0;
          if (env >= thr) phase = PH_OPENING;
          else if (gate == 0) phase = PH_CLOSED;
        end
      endcase

      // a voice started above is counted down on the same sample
      for (int v = 0; v < VOICES; v++) begin
        if (remain[v] > 0) begin
          remain[v]--;
          if (remain[v] == 0) w.ended_mask[v] = 1'b1;
        end
      end
      free_ok  = 1'b0;
      free_idx = 0;
      for (int v = VOICES - 1; v >= 0; v--) begin
        if (remain[v] == 0) begin
          free_ok  = 1'b1;
          free_idx = v;
        end
      end
      for (int v = 0; v < VOICES; v++) w.busy_mask[v] = (remain[v] != 0);

      w.gate_level     = LEVEL_W'(gate);
      w.gate_phase     = phase;
      w.envelope_level = ENV_BITS'(env);
      words_due = {words_due, w};
    endfunction

    function int field_bad(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 0;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
    endfunction

    function void check_word(gate_word_t got);
      gate_word_t want;
      if (words_due.size() == 0) begin
        failures++;
        $display("%0t: output word with nothing expected", $time);
        return;
      end
      want = words_due.pop_front();
      failures += field_bad("gate_level", want.gate_level, got.gate_level);
      failures += field_bad("gate_phase", want.gate_phase, got.gate_phase);
      failures += field_bad("envelope_level", want.envelope_level, got.envelope_level);
      failures += field_bad("grain_started", want.grain_started, got.grain_started);
      failures += field_bad("started_voice", want.started_voice, got.started_voice);
      failures += field_bad("ended_mask", want.ended_mask, got.ended_mask);
      failures += field_bad("busy_mask", want.busy_mask, got.busy_mask);
    endfunction

    function int pending();
      return words_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    bus_calm;
  gate_scoreboard        sb;

  gtva_in_if  #(.SAMPLE_BITS(SB))                     in_chan ();
  gtva_out_if #(.SAMPLE_BITS(SB), .NUM_VOICES(VOICES)) out_chan ();

  gate_triggered_voice_allocator #(
    .NUM_VOICES (VOICES),
    .SAMPLE_BITS(SB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SB-1:0] signed_of(int m);
    logic signed [SB-1:0] v;
    v = SB'(m);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic signed [SB-1:0] loud_sample();
    if ($urandom_range(0, 15) == 0) return S_MIN;
    return signed_of($urandom_range(8192, 32767));
  endfunction

  function automatic logic signed [SB-1:0] quiet_sample();
    return signed_of($urandom_range(0, 255));
  endfunction

  function automatic gate_setting_t make_setting(setting_kind_t kind);
    gate_setting_t s;
    case (kind)
      SET_STARVED: begin
        // long grains against fast gate cycles, so all voices fill up
        s.threshold = CFG_DATA_W'($urandom_range(1000, 20000));
        s.attack    = CFG_DATA_W'($urandom_range(16384, 32768));
        s.rls_step  = CFG_DATA_W'($urandom_range(16384, 32768));
        s.hold      = CFG_DATA_W'($urandom_range(0, 3));
        s.grain     = CFG_DATA_W'($urandom_range(150, 600));
        s.env_coef  = CFG_DATA_W'($urandom_range(40000, 65535));
      end
      SET_RAW: begin
        s.threshold = CFG_DATA_W'($urandom);
        s.attack    = CFG_DATA_W'($urandom);
        s.rls_step  = CFG_DATA_W'($urandom);
        s.hold      = CFG_DATA_W'($urandom_range(0, 255));
        s.grain     = CFG_DATA_W'($urandom_range(0, 255));
        s.env_coef  = CFG_DATA_W'($urandom);
      end
      SET_MIN: begin
        s.threshold = 0;
        s.attack    = 1;
        s.rls_step  = 1;
        s.hold      = 0;
        s.grain     = 0;
        s.env_coef  = 1;
      end
      SET_ALL_ONES: begin
        // upper data bits must be masked off per register
        s.threshold = '1;
        s.attack    = '1;
        s.rls_step  = '1;
        s.hold      = 0;
        s.grain     = 0;
        s.env_coef  = '1;
      end
      SET_MAX: begin
        s.threshold = 65536;
        s.attack    = 32768;
        s.rls_step  = 32768;
        s.hold      = 1048575;
        s.grain     = 1048575;
        s.env_coef  = 65535;
      end
      default: begin
        s.threshold = CFG_DATA_W'($urandom_range(256, 40000));
        s.attack    = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? 32768
                                                               : $urandom_range(1, 32768));
        s.rls_step  = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? 32768
                                                               : $urandom_range(1, 32768));
        s.hold      = CFG_DATA_W'($urandom_range(0, 20));
        s.grain     = CFG_DATA_W'($urandom_range(0, 60));
        s.env_coef  = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(30000, 65535)
                                                       : $urandom_range(200, 5000));
      end
    endcase
    return s;
  endfunction

  // valid stays high across back-to-back words; it drops only for a gap or a drain
  task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
    int gap;
    gap = (!bus_calm && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.left_sample  <= l;
    in_chan.right_sample <= r;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_pair(l, r);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input gate_setting_t s);
    write_reg(REG_OPEN_THRESHOLD, s.threshold);
    write_reg(REG_ATTACK_STEP, s.attack);
    write_reg(REG_RELEASE_STEP, s.rls_step);
    write_reg(REG_HOLD_SAMPLES, s.hold);
    write_reg(REG_GRAIN_SAMPLES, s.grain);
    write_reg(REG_ENVELOPE_RELEASE, s.env_coef);
    end_writes();
  endtask

  // loud bursts followed by quiet tails, with some raw noise mixed in
  task automatic run_phase(input int budget, output int sent);
    int len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 20) begin
        send_pair(SB'($urandom), SB'($urandom));
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) send_pair(loud_sample(), loud_sample());
        sent += len;
        len = $urandom_range(1, 30);
        repeat (len) send_pair(quiet_sample(), quiet_sample());
        sent += len;
      end
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  // output side: random stalls, checks every accepted word
  initial begin
    int         stall;
    gate_word_t got;
    stall = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.gate_level     = out_chan.gate_level;
        got.gate_phase     = out_chan.gate_phase;
        got.envelope_level = out_chan.envelope_level;
        got.grain_started  = out_chan.grain_started;
        got.started_voice  = out_chan.started_voice;
        got.ended_mask     = out_chan.ended_mask;
        got.busy_mask      = out_chan.busy_mask;
        sb.check_word(got);
      end
      if (stall > 0) begin
        stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!bus_calm && $urandom_range(0, 99) < 20) stall = pick_gap();
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("gate_triggered_voice_allocator verification failed");
    $finish;
  end

  initial begin
    gate_setting_t s;
    int            total;
    int            sent;
    int            idx;
    setting_kind_t kind;
    sb       = new();
    bus_calm = 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.left_sample  <= '0;
    in_chan.right_sample <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: sample extremes, sums stay under the threshold
    send_pair('0, '0);
    send_pair(S_MAX, -S_MAX);
    send_pair(S_MIN, '0);
    send_pair(-16'sd1, 16'sd1);
    drain();

    // one-sample grain ends on its start sample; spare indexes are dropped
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    apply_setting('{threshold: 1000, attack: 32768, rls_step: 32768, hold: 0,
                    grain: 1, env_coef: 65535});
    send_pair(S_MIN, S_MIN);
    send_pair(S_MIN, S_MIN);
    send_pair('0, '0);
    send_pair('0, '0);
    drain();

    // zero attack parks the gate in opening
    apply_setting('{threshold: 1000, attack: 0, rls_step: 8192, hold: 2,
                    grain: 0, env_coef: 65535});
    send_pair(16'sd20000, 16'sd20000);
    send_pair(16'sd20000, 16'sd20000);
    drain();
    write_reg(REG_ATTACK_STEP, 16384);
    end_writes();
    // open with zero-length grain, hold, close part way, reopen while closing
    send_pair(16'sd20000, 16'sd20000);
    send_pair(16'sd20000, 16'sd20000);
    send_pair(16'sd20000, 16'sd20000);
    send_pair('0, '0);
    send_pair('0, '0);
    send_pair('0, '0);
    send_pair(S_MIN, S_MAX);
    send_pair(S_MIN, S_MAX);
    drain();

    total = 0;
    idx   = 0;
    while (total < RANDOM_ITEMS) begin
      if (idx == 2) kind = SET_MIN;
      else if (idx == 5) kind = SET_ALL_ONES;
      else begin
        case ($urandom_range(0, 3))
          0:       kind = SET_STARVED;
          1:       kind = SET_RAW;
          default: kind = SET_TYPICAL;
        endcase
      end
      bus_calm = ($urandom_range(0, 3) == 0);
      apply_setting(make_setting(kind));
      run_phase($urandom_range(40, 120), sent);
      total += sent;
      idx++;
      drain();
    end

    // top of every range; only full-scale pairs reach the threshold
    bus_calm = 1'b0;
    apply_setting(make_setting(SET_MAX));
    repeat (3) send_pair(S_MIN, S_MIN);
    run_phase(60, sent);
    drain();

    if (sb.failures == 0 && sb.pending() == 0)
      $display("gate_triggered_voice_allocator verification clean");
    else
      $display("gate_triggered_voice_allocator verification failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/gtva_pkg.sv
hw/rtl/gtva_in_if.sv
hw/rtl/gtva_out_if.sv
hw/rtl/gtva_env.sv
hw/rtl/gtva_gate.sv
hw/rtl/gtva_voice_cell.sv
hw/rtl/gate_triggered_voice_allocator.sv
bench/tb.sv
